[sv/csm_pkg.sv]
// Shared constants and types for the colinear segment merge block.
`timescale 1ns / 1ps

package csm_pkg;

    // Width of every coordinate port.
    localparam int PORT_WIDTH = 32;

    // Default number of coordinate bits that take part in the geometry.
    localparam int COORD_WIDTH_DEF = 32;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_MERGED = 2'd1,
        ST_COND   = 2'd2
    } status_t;

endpackage

[sv/colinear_segment_merge_top.sv]
// Colinear segment merge: pipelined union of two line segments with colinearity test.
`timescale 1ns / 1ps

// Five register stages (input, order, classify, multiply, result) each hold one pair,
//   and a stage refills as soon as its content moves on; a transferred pair passes them
//   in order to the output at one pair per cycle while out_ready stays high.
// Reset (rst_n low, asynchronous): all stage valid flags clear, the output goes idle and
//   the block is ready for a transfer in the first cycle after reset.
module colinear_segment_merge_top
    import csm_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [PORT_WIDTH-1:0]   a_start_x,
    input  logic signed [PORT_WIDTH-1:0]   a_start_y,
    input  logic signed [PORT_WIDTH-1:0]   a_end_x,
    input  logic signed [PORT_WIDTH-1:0]   a_end_y,
    input  logic signed [PORT_WIDTH-1:0]   b_start_x,
    input  logic signed [PORT_WIDTH-1:0]   b_start_y,
    input  logic signed [PORT_WIDTH-1:0]   b_end_x,
    input  logic signed [PORT_WIDTH-1:0]   b_end_y,
    input  logic                           eligible,
    input  logic                           check_junctions,
    input  logic                           either_selected,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic signed [PORT_WIDTH-1:0]   merged_start_x,
    output logic signed [PORT_WIDTH-1:0]   merged_start_y,
    output logic signed [PORT_WIDTH-1:0]   merged_end_x,
    output logic signed [PORT_WIDTH-1:0]   merged_end_y,
    output logic                           merged_selected,
    output logic signed [PORT_WIDTH-1:0]   touch_x,
    output logic signed [PORT_WIDTH-1:0]   touch_y
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;       // coordinate difference
    localparam int PW = 2 * DW;       // exact product of two differences

    typedef logic signed [CW-1:0] crd_t;
    typedef logic signed [DW-1:0] dif_t;
    typedef logic signed [PW-1:0] prd_t;

    // Lexicographic order: x first, then y.
    function automatic logic pt_lt(input crd_t px, input crd_t py,
                                   input crd_t qx, input crd_t qy);
        logic r;
        r = (px == qx) ? (py < qy) : (px < qx);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage loads when it is empty or when its
    // content moves on in the same cycle; ready ripples back from the output.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic ld1, ld2, ld3, ld4, ld5;

    assign ld5      = !v5_reg || out_ready;
    assign ld4      = !v4_reg || ld5;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;
    assign out_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register. Keep the low COORD_WIDTH bits of each
    // coordinate, read as signed. Segment A plays the right-hand role and
    // segment B the left-hand role until the ordering stage decides.
    // ------------------------------------------------------------------
    crd_t s1_asx_reg, s1_asy_reg, s1_aex_reg, s1_aey_reg;
    crd_t s1_bsx_reg, s1_bsy_reg, s1_bex_reg, s1_bey_reg;
    logic s1_elig_reg, s1_cj_reg, s1_sel_reg;

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_asx_reg  <= a_start_x[CW-1:0];
            s1_asy_reg  <= a_start_y[CW-1:0];
            s1_aex_reg  <= a_end_x[CW-1:0];
            s1_aey_reg  <= a_end_y[CW-1:0];
            s1_bsx_reg  <= b_start_x[CW-1:0];
            s1_bsy_reg  <= b_start_y[CW-1:0];
            s1_bex_reg  <= b_end_x[CW-1:0];
            s1_bey_reg  <= b_end_y[CW-1:0];
            s1_elig_reg <= eligible;
            s1_cj_reg   <= check_junctions;
            s1_sel_reg  <= either_selected;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: order each segment's ends, then pick the leftmost segment.
    // ls/le: leftmost segment, os/oe: the other one.
    // ------------------------------------------------------------------
    logic a_swap, b_swap, lr_swap;
    crd_t rsx, rsy, rex, rey, lsx, lsy, lex, ley;
    crd_t s2_lsx_next, s2_lsy_next, s2_lex_next, s2_ley_next;
    crd_t s2_osx_next, s2_osy_next, s2_oex_next, s2_oey_next;

    always_comb
    begin
        a_swap = pt_lt(s1_aex_reg, s1_aey_reg, s1_asx_reg, s1_asy_reg);
        b_swap = pt_lt(s1_bex_reg, s1_bey_reg, s1_bsx_reg, s1_bsy_reg);
        rsx = a_swap ? s1_aex_reg : s1_asx_reg;
        rsy = a_swap ? s1_aey_reg : s1_asy_reg;
        rex = a_swap ? s1_asx_reg : s1_aex_reg;
        rey = a_swap ? s1_asy_reg : s1_aey_reg;
        lsx = b_swap ? s1_bex_reg : s1_bsx_reg;
        lsy = b_swap ? s1_bey_reg : s1_bsy_reg;
        lex = b_swap ? s1_bsx_reg : s1_bex_reg;
        ley = b_swap ? s1_bsy_reg : s1_bey_reg;
        lr_swap = pt_lt(rsx, rsy, lsx, lsy);
        s2_lsx_next = lr_swap ? rsx : lsx;
        s2_lsy_next = lr_swap ? rsy : lsy;
        s2_lex_next = lr_swap ? rex : lex;
        s2_ley_next = lr_swap ? rey : ley;
        s2_osx_next = lr_swap ? lsx : rsx;
        s2_osy_next = lr_swap ? lsy : rsy;
        s2_oex_next = lr_swap ? lex : rex;
        s2_oey_next = lr_swap ? ley : rey;
    end

    crd_t s2_lsx_reg, s2_lsy_reg, s2_lex_reg, s2_ley_reg;
    crd_t s2_osx_reg, s2_osy_reg, s2_oex_reg, s2_oey_reg;
    logic s2_elig_reg, s2_cj_reg, s2_sel_reg;

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_lsx_reg  <= s2_lsx_next;
            s2_lsy_reg  <= s2_lsy_next;
            s2_lex_reg  <= s2_lex_next;
            s2_ley_reg  <= s2_ley_next;
            s2_osx_reg  <= s2_osx_next;
            s2_osy_reg  <= s2_osy_next;
            s2_oex_reg  <= s2_oex_next;
            s2_oey_reg  <= s2_oey_next;
            s2_elig_reg <= s1_elig_reg;
            s2_cj_reg   <= s1_cj_reg;
            s2_sel_reg  <= s1_sel_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: classify. All compares and differences work in parallel
    // on the ordered ends.
    // ------------------------------------------------------------------
    logic contain, gap;
    crd_t rsfx, rsfy;
    crd_t s3_rex_next, s3_rey_next;
    logic s3_ok_next, s3_ident_next, s3_horiz_next, s3_hcol_next;
    logic s3_vert_next, s3_vcol_next, s3_touch_next;
    dif_t s3_dx_next, s3_dy_next, s3_d1_next, s3_d2_next, s3_d3_next, s3_d4_next;

    always_comb
    begin
        // Other segment lies within the leftmost one: merged end is le.
        contain = pt_lt(s2_oex_reg, s2_oey_reg, s2_lex_reg, s2_ley_reg);
        gap     = pt_lt(s2_lex_reg, s2_ley_reg, s2_osx_reg, s2_osy_reg);
        s3_rex_next = contain ? s2_lex_reg : s2_oex_reg;
        s3_rey_next = contain ? s2_ley_reg : s2_oey_reg;
        rsfx        = contain ? s2_lsx_reg : s2_osx_reg;
        rsfy        = contain ? s2_lsy_reg : s2_osy_reg;
        s3_ok_next    = s2_elig_reg && !gap;
        s3_ident_next = (s2_lsx_reg == s2_osx_reg) && (s2_lsy_reg == s2_osy_reg)
                     && (s2_lex_reg == s2_oex_reg) && (s2_ley_reg == s2_oey_reg);
        s3_horiz_next = (s2_lsy_reg == s2_ley_reg) && (s2_osy_reg == s2_oey_reg);
        s3_hcol_next  = (s2_lsy_reg == s2_osy_reg);
        s3_vert_next  = (s2_lsx_reg == s2_lex_reg) && (s2_osx_reg == s2_oex_reg);
        s3_vcol_next  = (s2_lsx_reg == s2_osx_reg);
        s3_touch_next = (s2_lex_reg == rsfx) && (s2_ley_reg == rsfy);
        s3_dx_next = dif_t'(s2_lex_reg) - dif_t'(s2_lsx_reg);
        s3_dy_next = dif_t'(s2_ley_reg) - dif_t'(s2_lsy_reg);
        s3_d1_next = dif_t'(s2_osy_reg) - dif_t'(s2_lsy_reg);
        s3_d2_next = dif_t'(s2_osx_reg) - dif_t'(s2_lsx_reg);
        s3_d3_next = dif_t'(s2_oey_reg) - dif_t'(s2_lsy_reg);
        s3_d4_next = dif_t'(s2_oex_reg) - dif_t'(s2_lsx_reg);
    end

    crd_t s3_lsx_reg, s3_lsy_reg, s3_lex_reg, s3_ley_reg, s3_rex_reg, s3_rey_reg;
    logic s3_ok_reg, s3_ident_reg, s3_horiz_reg, s3_hcol_reg;
    logic s3_vert_reg, s3_vcol_reg, s3_touch_reg, s3_cj_reg, s3_sel_reg;
    dif_t s3_dx_reg, s3_dy_reg, s3_d1_reg, s3_d2_reg, s3_d3_reg, s3_d4_reg;

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            s3_lsx_reg   <= s2_lsx_reg;
            s3_lsy_reg   <= s2_lsy_reg;
            s3_lex_reg   <= s2_lex_reg;
            s3_ley_reg   <= s2_ley_reg;
            s3_rex_reg   <= s3_rex_next;
            s3_rey_reg   <= s3_rey_next;
            s3_ok_reg    <= s3_ok_next;
            s3_ident_reg <= s3_ident_next;
            s3_horiz_reg <= s3_horiz_next;
            s3_hcol_reg  <= s3_hcol_next;
            s3_vert_reg  <= s3_vert_next;
            s3_vcol_reg  <= s3_vcol_next;
            s3_touch_reg <= s3_touch_next;
            s3_cj_reg    <= s2_cj_reg;
            s3_sel_reg   <= s2_sel_reg;
            s3_dx_reg    <= s3_dx_next;
            s3_dy_reg    <= s3_dy_next;
            s3_d1_reg    <= s3_d1_next;
            s3_d2_reg    <= s3_d2_next;
            s3_d3_reg    <= s3_d3_next;
            s3_d4_reg    <= s3_d4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: four exact cross-product terms, one multiplier each.
    // Comparing the signed products directly is exact at this width.
    // ------------------------------------------------------------------
    crd_t s4_lsx_reg, s4_lsy_reg, s4_lex_reg, s4_ley_reg, s4_rex_reg, s4_rey_reg;
    logic s4_ok_reg, s4_ident_reg, s4_horiz_reg, s4_hcol_reg;
    logic s4_vert_reg, s4_vcol_reg, s4_touch_reg, s4_cj_reg, s4_sel_reg;
    prd_t s4_pa_reg, s4_pb_reg, s4_pc_reg, s4_pd_reg;

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            s4_lsx_reg   <= s3_lsx_reg;
            s4_lsy_reg   <= s3_lsy_reg;
            s4_lex_reg   <= s3_lex_reg;
            s4_ley_reg   <= s3_ley_reg;
            s4_rex_reg   <= s3_rex_reg;
            s4_rey_reg   <= s3_rey_reg;
            s4_ok_reg    <= s3_ok_reg;
            s4_ident_reg <= s3_ident_reg;
            s4_horiz_reg <= s3_horiz_reg;
            s4_hcol_reg  <= s3_hcol_reg;
            s4_vert_reg  <= s3_vert_reg;
            s4_vcol_reg  <= s3_vcol_reg;
            s4_touch_reg <= s3_touch_reg;
            s4_cj_reg    <= s3_cj_reg;
            s4_sel_reg   <= s3_sel_reg;
            s4_pa_reg    <= prd_t'(s3_d1_reg) * prd_t'(s3_dx_reg);
            s4_pb_reg    <= prd_t'(s3_d2_reg) * prd_t'(s3_dy_reg);
            s4_pc_reg    <= prd_t'(s3_d3_reg) * prd_t'(s3_dx_reg);
            s4_pd_reg    <= prd_t'(s3_d4_reg) * prd_t'(s3_dy_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: decide status and drive the result register. A rejected
    // pair returns all zeros; the touch point is nonzero only on a
    // conditional merge.
    // ------------------------------------------------------------------
    logic    colinear, merge, cond;
    status_t status_next;
    crd_t    msx_next, msy_next, mex_next, mey_next, tx_next, ty_next;
    logic    msel_next;

    always_comb
    begin
        if (s4_horiz_reg)
            colinear = s4_hcol_reg;
        else if (s4_vert_reg)
            colinear = s4_vcol_reg;
        else
            colinear = (s4_pa_reg == s4_pb_reg) && (s4_pc_reg == s4_pd_reg);

        merge = s4_ok_reg && (s4_ident_reg || colinear);
        cond  = merge && !s4_ident_reg && s4_touch_reg && s4_cj_reg;

        status_next = cond ? ST_COND : (merge ? ST_MERGED : ST_NONE);
        msx_next  = merge ? s4_lsx_reg : '0;
        msy_next  = merge ? s4_lsy_reg : '0;
        mex_next  = merge ? s4_rex_reg : '0;
        mey_next  = merge ? s4_rey_reg : '0;
        msel_next = merge && s4_sel_reg;
        tx_next   = cond ? s4_lex_reg : '0;
        ty_next   = cond ? s4_ley_reg : '0;
    end

    status_t status_reg;
    crd_t    msx_reg, msy_reg, mex_reg, mey_reg, tx_reg, ty_reg;
    logic    msel_reg;

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            status_reg <= status_next;
            msx_reg    <= msx_next;
            msy_reg    <= msy_next;
            mex_reg    <= mex_next;
            mey_reg    <= mey_next;
            msel_reg   <= msel_next;
            tx_reg     <= tx_next;
            ty_reg     <= ty_next;
        end
    end

    // Sign-extend the kept coordinate bits back to port width.
    assign status          = status_reg;
    assign merged_start_x  = PORT_WIDTH'(msx_reg);
    assign merged_start_y  = PORT_WIDTH'(msy_reg);
    assign merged_end_x    = PORT_WIDTH'(mex_reg);
    assign merged_end_y    = PORT_WIDTH'(mey_reg);
    assign merged_selected = msel_reg;
    assign touch_x         = PORT_WIDTH'(tx_reg);
    assign touch_y         = PORT_WIDTH'(ty_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_NONE) |->
            (merged_start_x == 0 && merged_start_y == 0 && merged_end_x == 0
             && merged_end_y == 0 && !merged_selected && touch_x == 0 && touch_y == 0))
        else $error("rejected pair carries nonzero fields");

    a_merged_no_touch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_MERGED) |-> (touch_x == 0 && touch_y == 0))
        else $error("touch point set on unconditional merge");

    a_merged_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_NONE) |->
            (merged_start_x < merged_end_x
             || (merged_start_x == merged_end_x && merged_start_y <= merged_end_y)))
        else $error("merged start lies after merged end");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !out_ready) |-> !in_ready)
        else $error("transfer taken while every stage is held");

endmodule
